[rtl/wdsd_pkg.sv]
`timescale 1ns / 1ps

package wdsd_pkg;

  // Field widths
  localparam int unsigned NOW_W    = 48;
  localparam int unsigned HEIGHT_W = 24;
  localparam int unsigned SPEED_W  = 24;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned LIMIT_W  = 23;
  localparam int unsigned STRIKE_W = 4;

  // Default window length
  localparam int unsigned WINDOW_DEF = 20;

  // Configuration bus
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_CHECK_PERIOD = 2'd0;
  localparam logic [1:0] REG_HEIGHT_LIMIT = 2'd1;
  localparam logic [1:0] REG_STRIKE_LIMIT = 2'd2;

  // Register reset values
  localparam logic [PERIOD_W-1:0] CHECK_PERIOD_RST = 16'd1000;
  localparam logic [LIMIT_W-1:0]  HEIGHT_LIMIT_RST = 23'd200;
  localparam logic [STRIKE_W-1:0] STRIKE_LIMIT_RST = 4'd3;

endpackage

[rtl/window_deviation_strike_detector_top.sv]
`timescale 1ns / 1ps

// Window deviation strike detector.
// Input channel (in_valid / in_stall) carries one sample item: time stamp in ms,
// signed height in cm and signed vertical speed. Result channel (out_valid /
// out_stall) returns one item per sample: checked, floating, suspect and the
// strike count after that sample.
// Heights go into a ring of the last WINDOW samples with a running sum; a
// periodic check compares |WINDOW*height - sum| against WINDOW*height_limit.
// Throughput: one item per cycle while the receiver does not stall. An accepted
// item passes through one input register and one single-pass compute stage into
// the result register, which drives out_valid. The path is set by the running-sum
// update and the deviation compare, both done in the same cycle so the next
// sample sees them.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; in_stall rises only once both are full.
// Configuration goes through the APB port (registers at 0x0, 0x4, 0x8); the
// user must write it only while the block is idle; the block does not enforce it.
// Reset (rst_n low, synchronous) empties both registers, clears the window
// fill, sum, pointer, check time and strike count, and restores register
// defaults. Ring contents are not reset; the fill count guards them.

module window_deviation_strike_detector_top #(
  parameter int unsigned WINDOW = wdsd_pkg::WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [wdsd_pkg::NOW_W-1:0]           in_now_ms,
  input  logic signed [wdsd_pkg::HEIGHT_W-1:0] in_height,
  input  logic signed [wdsd_pkg::SPEED_W-1:0]  in_vertical_speed,

  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_checked,
  output logic                                 out_floating,
  output logic                                 out_suspect,
  output logic [wdsd_pkg::STRIKE_W-1:0]        out_strike_count,

  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [wdsd_pkg::ADDR_W-1:0]          paddr,
  input  logic [wdsd_pkg::DATA_W-1:0]          pwdata,
  output logic [wdsd_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);

  localparam int unsigned PTR_W  = $clog2(WINDOW);
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = wdsd_pkg::HEIGHT_W + $clog2(WINDOW);
  localparam int unsigned DEV_W  = SUM_W + 1;
  localparam logic signed [SUM_W-1:0] WIN_S    = SUM_W'(WINDOW);
  localparam logic [DEV_W-1:0]        WIN_U    = DEV_W'(WINDOW);
  localparam logic [FILL_W-1:0]       FILL_MAX = FILL_W'(WINDOW);
  localparam logic [FILL_W-1:0]       FILL_LST = FILL_W'(WINDOW - 1);
  localparam logic [PTR_W-1:0]        PTR_LST  = PTR_W'(WINDOW - 1);

  // Configuration registers
  logic [wdsd_pkg::PERIOD_W-1:0] period_r;
  logic [wdsd_pkg::LIMIT_W-1:0]  limit_r;
  logic [wdsd_pkg::STRIKE_W-1:0] strike_lim_r;
  logic                          cfg_wr;

  // Input register
  logic                                 in_vld_r;
  logic [wdsd_pkg::NOW_W-1:0]           now_r;
  logic signed [wdsd_pkg::HEIGHT_W-1:0] height_r;
  logic signed [wdsd_pkg::SPEED_W-1:0]  speed_r;

  // Window and check state
  logic signed [wdsd_pkg::HEIGHT_W-1:0] ring_r [WINDOW];
  logic [PTR_W-1:0]              ptr_r, ptr_nxt;
  logic [FILL_W-1:0]             fill_r, fill_nxt;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic [wdsd_pkg::NOW_W-1:0]    last_r, last_nxt;
  logic [wdsd_pkg::STRIKE_W-1:0] strikes_r, strikes_nxt;

  // Result register
  logic                          out_vld_r;
  logic                          checked_r, checked_nxt;
  logic                          floating_r, floating_nxt;
  logic                          suspect_r, suspect_nxt;
  logic [wdsd_pkg::STRIKE_W-1:0] count_r;

  // Datapath temporaries
  logic                          adv;
  logic                          full;
  logic                          full_nxt;
  logic signed [SUM_W-1:0]       h_ext;
  logic signed [SUM_W-1:0]       win_h;
  logic signed [SUM_W-1:0]       old_h;
  logic signed [DEV_W-1:0]       dev;
  logic [DEV_W-1:0]              mag;
  logic [DEV_W-1:0]              thr;
  logic                          reset_time;
  logic [wdsd_pkg::NOW_W-1:0]    elapsed;
  logic [wdsd_pkg::STRIKE_W-1:0] inc;

  // Config write / read
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= wdsd_pkg::CHECK_PERIOD_RST;
      limit_r      <= wdsd_pkg::HEIGHT_LIMIT_RST;
      strike_lim_r <= wdsd_pkg::STRIKE_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        wdsd_pkg::REG_CHECK_PERIOD: period_r     <= pwdata[wdsd_pkg::PERIOD_W-1:0];
        wdsd_pkg::REG_HEIGHT_LIMIT: limit_r      <= pwdata[wdsd_pkg::LIMIT_W-1:0];
        wdsd_pkg::REG_STRIKE_LIMIT: strike_lim_r <= pwdata[wdsd_pkg::STRIKE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      wdsd_pkg::REG_CHECK_PERIOD: prdata = wdsd_pkg::DATA_W'(period_r);
      wdsd_pkg::REG_HEIGHT_LIMIT: prdata = wdsd_pkg::DATA_W'(limit_r);
      wdsd_pkg::REG_STRIKE_LIMIT: prdata = wdsd_pkg::DATA_W'(strike_lim_r);
      default:                    prdata = '0;
    endcase
  end

  // Flow control: compute stage advances when the result register is free
  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      now_r    <= in_now_ms;
      height_r <= in_height;
      speed_r  <= in_vertical_speed;
    end
  end

  // Window update
  always_comb begin
    full     = (fill_r == FILL_MAX);
    full_nxt = full || (fill_r == FILL_LST);
    fill_nxt = full ? fill_r : fill_r + 1'b1;
    h_ext    = SUM_W'(height_r);
    old_h    = SUM_W'(ring_r[ptr_r]);
    sum_nxt  = (full ? sum_r - old_h : sum_r) + h_ext;
    ptr_nxt  = (ptr_r == PTR_LST) ? '0 : ptr_r + 1'b1;
  end

  // Period check; a check time that snaps to now never triggers a check
  always_comb begin
    reset_time  = (last_r == '0) || (last_r > now_r);
    elapsed     = now_r - last_r;
    checked_nxt = !reset_time && (elapsed > wdsd_pkg::NOW_W'(period_r));
    if (checked_nxt || reset_time) begin
      last_nxt = now_r;
    end else begin
      last_nxt = last_r;
    end
  end

  // Deviation test against the window including this sample
  always_comb begin
    win_h        = h_ext * WIN_S;
    dev          = DEV_W'(win_h) - DEV_W'(sum_nxt);
    mag          = dev[DEV_W-1] ? DEV_W'(-dev) : DEV_W'(dev);
    thr          = DEV_W'(limit_r) * WIN_U;
    floating_nxt = checked_nxt && full_nxt && (speed_r == '0) && (mag > thr);
  end

  // Strike counting
  always_comb begin
    inc         = strikes_r + 1'b1;
    suspect_nxt = 1'b0;
    strikes_nxt = strikes_r;
    if (checked_nxt) begin
      if (floating_nxt) begin
        if (inc >= strike_lim_r) begin
          suspect_nxt = 1'b1;
          strikes_nxt = '0;
        end else begin
          strikes_nxt = inc;
        end
      end else begin
        strikes_nxt = '0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      fill_r    <= '0;
      sum_r     <= '0;
      last_r    <= '0;
      strikes_r <= '0;
    end else if (in_vld_r && adv) begin
      ptr_r     <= ptr_nxt;
      fill_r    <= fill_nxt;
      sum_r     <= sum_nxt;
      last_r    <= last_nxt;
      strikes_r <= strikes_nxt;
    end
  end

  // Ring storage, no reset
  always_ff @(posedge clk) begin
    if (in_vld_r && adv) begin
      ring_r[ptr_r] <= height_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r && adv) begin
      checked_r  <= checked_nxt;
      floating_r <= floating_nxt;
      suspect_r  <= suspect_nxt;
      count_r    <= strikes_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_checked      = checked_r;
  assign out_floating     = floating_r;
  assign out_suspect      = suspect_r;
  assign out_strike_count = count_r;

endmodule
